### sv/cdf_pkg.sv
// Shared types and constants of the chunked message deframer.
`default_nettype none

package cdf_pkg;

	// Register indexes on the configuration port (byte address is four times the index)
	typedef enum logic [1:0] {
		REG_MARKER   = 2'd0,
		REG_MAGIC    = 2'd1,
		REG_MAX_LEN  = 2'd2,
		REG_CAPACITY = 2'd3
	} reg_idx_t;

	typedef enum logic [2:0] {
		ST_OK         = 3'd0,
		ST_MISALIGNED = 3'd1,
		ST_BAD_HEADER = 3'd2,
		ST_TOO_LONG   = 3'd3,
		ST_TRUNCATED  = 3'd4,
		ST_BAD_CONT   = 3'd5
	} status_t;

	// Byte offsets of the header fields within the first chunk
	localparam int POS_MARKER   = 0;
	localparam int POS_MAGIC_LO = 1;
	localparam int POS_MAGIC_HI = 2;
	localparam int POS_TYPE_LO  = 3;
	localparam int POS_TYPE_HI  = 4;
	localparam int POS_LEN_LO   = 5;
	localparam int POS_LEN_HI   = 8;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

	typedef struct packed {
		logic [7:0]  marker;
		logic [7:0]  magic;
		logic [31:0] max_len;
		logic [31:0] capacity;
	} cfg_t;

	// One queue entry: the work caused by one accepted byte
	typedef struct packed {
		logic        has_pay;
		logic [7:0]  pay_byte;
		logic        has_stat;
		logic [15:0] kind;
		logic [31:0] len;
		status_t     status;
	} cmd_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  pay_byte;
		logic [15:0] msg_kind;
		logic [31:0] len;
		status_t     status;
		logic        final_item;
	} res_t;

endpackage

`default_nettype wire

### sv/cdf_regs.sv
// Configuration register file behind the APB-style port.
`default_nettype none

module cdf_regs (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire logic         psel,
	input  wire logic         penable,
	input  wire logic         pwrite,
	input  wire logic [3:0]   paddr,
	input  wire logic [31:0]  pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	output cdf_pkg::cfg_t     cfg
);

	cdf_pkg::cfg_t     cfg_q;
	cdf_pkg::reg_idx_t idx;
	logic              wr_en;

	assign idx    = cdf_pkg::reg_idx_t'(paddr[3:2]);
	assign wr_en  = psel & penable & pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.marker   <= 8'd63;
			cfg_q.magic    <= 8'd35;
			cfg_q.max_len  <= 32'd65535;
			cfg_q.capacity <= 32'd65535;
		end else if (wr_en) begin
			unique case (idx)
				cdf_pkg::REG_MARKER:   cfg_q.marker   <= pwdata[7:0];
				cdf_pkg::REG_MAGIC:    cfg_q.magic    <= pwdata[7:0];
				cdf_pkg::REG_MAX_LEN:  cfg_q.max_len  <= pwdata;
				cdf_pkg::REG_CAPACITY: cfg_q.capacity <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			cdf_pkg::REG_MARKER:   prdata = {24'd0, cfg_q.marker};
			cdf_pkg::REG_MAGIC:    prdata = {24'd0, cfg_q.magic};
			cdf_pkg::REG_MAX_LEN:  prdata = cfg_q.max_len;
			cdf_pkg::REG_CAPACITY: prdata = cfg_q.capacity;
			default:               prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire

### sv/cdf_front.sv
// Front end: accepts stream bytes, tracks chunk position and header, classifies each byte.
`default_nettype none

module cdf_front #(
	parameter int CHUNK_BYTES = 64
) (
	input  wire logic         clk,
	input  wire logic         arst_n,
	input  wire cdf_pkg::cfg_t cfg,
	input  wire logic         wire_valid,
	output logic              wire_ready,
	input  wire logic [7:0]   wire_byte,
	input  wire logic         end_of_input,
	input  wire logic         full,
	output logic              push,
	output cdf_pkg::cmd_t     push_cmd
);

	localparam int PW = $clog2(CHUNK_BYTES);

	localparam logic [PW-1:0] P_MARKER   = PW'(cdf_pkg::POS_MARKER);
	localparam logic [PW-1:0] P_MAGIC_LO = PW'(cdf_pkg::POS_MAGIC_LO);
	localparam logic [PW-1:0] P_MAGIC_HI = PW'(cdf_pkg::POS_MAGIC_HI);
	localparam logic [PW-1:0] P_TYPE_LO  = PW'(cdf_pkg::POS_TYPE_LO);
	localparam logic [PW-1:0] P_TYPE_HI  = PW'(cdf_pkg::POS_TYPE_HI);
	localparam logic [PW-1:0] P_LEN_LO   = PW'(cdf_pkg::POS_LEN_LO);
	localparam logic [PW-1:0] P_LEN_HI   = PW'(cdf_pkg::POS_LEN_HI);
	localparam logic [PW-1:0] P_LAST     = PW'(CHUNK_BYTES - 1);

	logic [PW-1:0] pos_q;
	logic          first_q;
	logic [15:0]   type_q, type_n;
	logic [31:0]   len_q, len_n;
	logic [31:0]   count_q, count_n;
	// sticky errors: bad header, too long, bad continuation
	logic          hdr_err_q, hdr_err_n;
	logic          long_err_q, long_err_n;
	logic          cont_err_q, cont_err_n;

	logic take, payload_pos, needed, emit_pay, chunk_end, short_n;
	cdf_pkg::status_t status;

	assign wire_ready = ~full;
	assign take       = wire_valid & ~full;
	assign needed     = count_q < len_q;
	assign chunk_end  = pos_q == P_LAST;

	always_comb begin
		type_n      = type_q;
		len_n       = len_q;
		hdr_err_n   = hdr_err_q;
		long_err_n  = long_err_q;
		cont_err_n  = cont_err_q;
		payload_pos = 1'b0;
		if (first_q) begin
			if (pos_q == P_MARKER) begin
				if (wire_byte != cfg.marker) hdr_err_n = 1'b1;
			end else if (pos_q == P_MAGIC_LO || pos_q == P_MAGIC_HI) begin
				if (wire_byte != cfg.magic) hdr_err_n = 1'b1;
			end else if (pos_q == P_TYPE_LO || pos_q == P_TYPE_HI) begin
				type_n = {type_q[7:0], wire_byte};
			end else if (pos_q >= P_LEN_LO && pos_q <= P_LEN_HI) begin
				len_n = {len_q[23:0], wire_byte};
				if (pos_q == P_LEN_HI && (len_n > cfg.max_len || len_n > cfg.capacity))
					long_err_n = 1'b1;
			end else begin
				payload_pos = 1'b1;
			end
		end else if (pos_q == P_MARKER) begin
			// padding chunks carry no marker check
			if (needed && wire_byte != cfg.marker) cont_err_n = 1'b1;
		end else begin
			payload_pos = 1'b1;
		end

		emit_pay = payload_pos & needed & ~hdr_err_q & ~long_err_q & ~cont_err_q;
		count_n  = count_q + {31'd0, payload_pos & needed};
		short_n  = count_n < len_n;

		if (!chunk_end)     status = cdf_pkg::ST_MISALIGNED;
		else if (hdr_err_n)  status = cdf_pkg::ST_BAD_HEADER;
		else if (long_err_n) status = cdf_pkg::ST_TOO_LONG;
		else if (short_n)    status = cdf_pkg::ST_TRUNCATED;
		else if (cont_err_n) status = cdf_pkg::ST_BAD_CONT;
		else                 status = cdf_pkg::ST_OK;
	end

	assign push              = take & (emit_pay | end_of_input);
	assign push_cmd.has_pay  = emit_pay;
	assign push_cmd.pay_byte = wire_byte;
	assign push_cmd.has_stat = end_of_input;
	assign push_cmd.kind     = type_n;
	assign push_cmd.len      = len_n;
	assign push_cmd.status   = status;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q      <= '0;
			first_q    <= 1'b1;
			type_q     <= '0;
			len_q      <= '0;
			count_q    <= '0;
			hdr_err_q  <= 1'b0;
			long_err_q <= 1'b0;
			cont_err_q <= 1'b0;
		end else if (take) begin
			if (end_of_input) begin
				// message done: back to the start of a new one
				pos_q      <= '0;
				first_q    <= 1'b1;
				type_q     <= '0;
				len_q      <= '0;
				count_q    <= '0;
				hdr_err_q  <= 1'b0;
				long_err_q <= 1'b0;
				cont_err_q <= 1'b0;
			end else begin
				pos_q      <= chunk_end ? '0 : pos_q + 1'b1;
				first_q    <= first_q & ~chunk_end;
				type_q     <= type_n;
				len_q      <= len_n;
				count_q    <= count_n;
				hdr_err_q  <= hdr_err_n;
				long_err_q <= long_err_n;
				cont_err_q <= cont_err_n;
			end
		end
	end

endmodule

`default_nettype wire

### sv/cdf_queue.sv
// Short command queue between the front end and the output stage.
`default_nettype none

module cdf_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          push,
	input  wire cdf_pkg::cmd_t push_cmd,
	output logic               full,
	input  wire logic          pop,
	output logic               empty,
	output cdf_pkg::cmd_t      head
);

	localparam int DEPTH = cdf_pkg::QUEUE_DEPTH;
	localparam int AW    = cdf_pkg::QPTR_W;

	cdf_pkg::cmd_t      entry_q [DEPTH];
	logic [AW-1:0]      wr_ptr_q, rd_ptr_q;
	logic [AW:0]        count_q;

	assign full  = count_q == (AW+1)'(DEPTH);
	assign empty = count_q == '0;
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) entry_q[wr_ptr_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= rd_ptr_q + 1'b1;
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

`default_nettype wire

### sv/cdf_back.sv
// Output stage: turns queued commands into result items and holds them for the receiver.
`default_nettype none

module cdf_back (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          empty,
	input  wire cdf_pkg::cmd_t head,
	output logic               pop,
	output logic               result_valid,
	input  wire logic          result_ready,
	output cdf_pkg::res_t      result
);

	logic          valid_q;
	logic          pay_done_q;
	cdf_pkg::res_t res_q;

	logic          can_load, load, send_pay, pay_done_n;
	cdf_pkg::res_t res_n;

	assign can_load     = ~valid_q | result_ready;
	assign load         = can_load & ~empty;
	assign send_pay     = head.has_pay & ~pay_done_q;
	assign result_valid = valid_q;
	assign result       = res_q;

	always_comb begin
		res_n      = '0;
		pop        = 1'b0;
		pay_done_n = pay_done_q;
		if (send_pay) begin
			res_n.kind     = 1'b0;
			res_n.pay_byte = head.pay_byte;
			res_n.status   = cdf_pkg::ST_OK;
		end else begin
			res_n.kind       = 1'b1;
			res_n.msg_kind   = head.kind;
			res_n.len        = head.len;
			res_n.status     = head.status;
			res_n.final_item = 1'b1;
		end
		if (load) begin
			// keep the entry queued when it also carries a status item, which is loaded next
			if (send_pay && head.has_stat) begin
				pay_done_n = 1'b1;
			end else begin
				pop        = 1'b1;
				pay_done_n = 1'b0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q    <= 1'b0;
			pay_done_q <= 1'b0;
		end else begin
			pay_done_q <= pay_done_n;
			if (can_load) valid_q <= ~empty;
		end
	end

	always_ff @(posedge clk) begin
		if (load) res_q <= res_n;
	end

endmodule

`default_nettype wire

### sv/chunked_message_deframer_top.sv
// Chunked message deframer: byte stream in, payload bytes and a status item out.
// Input channel: wire_valid/wire_ready carry one stream byte per item, with
// end_of_input set on the last byte of a message. Output channel:
// result_valid/result_ready carry payload items (result_kind 0) and the
// closing status item (result_kind 1, final_item 1) with type, length, status.
// The APB-style port holds marker, magic, length limit and capacity; write it
// only while no message is in flight.
// A result passes through the command queue and the output register before it
// is offered. Throughput: one byte per cycle while the queue is not full; a
// payload byte that also ends the message yields two items. A four-entry command
// queue sits between the byte classifier and the output register, so input
// keeps flowing while a result waits; when the receiver stalls long enough to
// fill the queue, wire_ready drops until room frees up.
// Reset: the message tracker returns to the start of a first chunk, the queue
// and output register empty, and the registers take their defaults.
`default_nettype none

module chunked_message_deframer_top #(
	parameter int CHUNK_BYTES = 64
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        wire_valid,
	output logic             wire_ready,
	input  wire logic [7:0]  wire_byte,
	input  wire logic        end_of_input,
	output logic             result_valid,
	input  wire logic        result_ready,
	output logic             result_kind,
	output logic [7:0]       payload_byte,
	output logic [15:0]      message_kind,
	output logic [31:0]      payload_length,
	output logic [2:0]       status_code,
	output logic             final_item
);

	cdf_pkg::cfg_t cfg;
	cdf_pkg::cmd_t push_cmd, head;
	cdf_pkg::res_t result;
	logic          push, pop, full, empty;

	cdf_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cdf_front #(
		.CHUNK_BYTES (CHUNK_BYTES)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg          (cfg),
		.wire_valid   (wire_valid),
		.wire_ready   (wire_ready),
		.wire_byte    (wire_byte),
		.end_of_input (end_of_input),
		.full         (full),
		.push         (push),
		.push_cmd     (push_cmd)
	);

	cdf_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (full),
		.pop      (pop),
		.empty    (empty),
		.head     (head)
	);

	cdf_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.empty        (empty),
		.head         (head),
		.pop          (pop),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	assign result_kind    = result.kind;
	assign payload_byte   = result.pay_byte;
	assign message_kind   = result.msg_kind;
	assign payload_length = result.len;
	assign status_code    = result.status;
	assign final_item     = result.final_item;

endmodule

`default_nettype wire
